FILE: rtl/lvsm_pkg.sv
// Shared constants, codes and types of the latest-value slot manager.
`timescale 1ns / 1ps

package lvsm_pkg;

    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int SIU_W      = 5;
    localparam int CMP_W      = (CNT_W > SIU_W) ? CNT_W : SIU_W;
    localparam int IDX_W      = 4;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [SIU_W-1:0]      SIU_RESET    = 5'd16;
    localparam logic [CFG_DATA_W-1:0] EXPIRY_RESET = 32'd2000000;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_TIME  = 1'd1;

    localparam logic [MODE_W-1:0] MODE_ALLOCATE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COMMIT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NEWEST    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_OLDEST    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UPDATED   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ_SLOT = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NODATA  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXPIRED = 3'd4;

    typedef struct packed {
        logic        owned;
        logic [63:0] seq;
        logic [31:0] size;
        logic [63:0] mono_time;
        logic [63:0] real_time;
    } entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        entry_t            wr_data;
    } tbl_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    found_slot;
        logic [63:0]         seq;
        logic [31:0]         size;
        logic [63:0]         mono_time;
        logic [63:0]         real_time;
        logic                has_update;
    } result_t;

endpackage

FILE: rtl/lvsm_table.sv
// Slot table memory with registered read and per-slot valid bits.
`timescale 1ns / 1ps

module lvsm_table
    import lvsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_req_t req,
    output entry_t   rd_data
);

    entry_t                 mem [MAX_SLOTS];
    entry_t                 rd_data_reg;
    logic [MAX_SLOTS-1:0]   valid_reg;
    logic [MAX_SLOTS-1:0]   valid_next;
    logic                   rd_valid_reg;
    logic                   rd_valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.wr_en)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
        rd_valid_next = req.rd_en ? valid_reg[req.rd_addr] : rd_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // never-written slots read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: rtl/lvsm_ctrl.sv
// Request sequencer: single-slot read-modify-write and table scans.
`timescale 1ns / 1ps

module lvsm_ctrl
    import lvsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [MODE_W-1:0]     mode,
    input  logic [IDX_W-1:0]      slot_index,
    input  logic [31:0]           payload_size,
    input  logic [63:0]           capture_time,
    input  logic [63:0]           now_monotonic,
    input  logic [63:0]           now_realtime,
    input  logic [SIU_W-1:0]      slots_in_use,
    input  logic [CFG_DATA_W-1:0] expiry_time,
    output tbl_req_t              tbl_req,
    input  entry_t                tbl_rd_data,
    output logic                  res_valid,
    input  logic                  res_take,
    output result_t               res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_MODIFY = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [31:0]       size_reg, size_next;
    logic [63:0]       cap_reg, cap_next;
    logic [63:0]       nowm_reg, nowm_next;
    logic [63:0]       nowr_reg, nowr_next;
    logic [63:0]       gseq_reg, gseq_next;
    logic [63:0]       lr_seq_reg, lr_seq_next;
    logic [SLOT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [SLOT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [63:0]       best_seq_reg, best_seq_next;
    logic [SLOT_W-1:0] best_idx_reg, best_idx_next;
    entry_t            best_ent_reg, best_ent_next;
    logic              found_reg, found_next;
    logic              hit_reg, hit_next;
    result_t           res_reg, res_next;

    logic [CMP_W-1:0]  siu_ext;
    logic [CMP_W-1:0]  n_ext;
    logic [CNT_W-1:0]  n_act;
    logic              in_range_new;
    logic              in_acc;
    logic              take_best;
    entry_t            new_ent;
    logic [63:0]       age;

    assign siu_ext      = CMP_W'(slots_in_use);
    assign n_ext        = (siu_ext > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : siu_ext;
    assign n_act        = CNT_W'(n_ext);
    assign in_range_new = CMP_W'(slot_index) < n_ext;
    assign in_acc       = in_valid && (state_reg == S_IDLE);
    assign in_stall     = (state_reg != S_IDLE);
    assign res_valid    = (state_reg == S_DONE);
    assign res          = res_reg;
    assign age          = nowm_reg - best_ent_reg.mono_time;

    always_comb
    begin
        case (mode_reg)
            MODE_NEWEST: take_best = tbl_rd_data.seq > best_seq_reg;
            MODE_OLDEST: take_best = (tbl_rd_data.seq < best_seq_reg) || (cmp_idx_reg == '0);
            default:     take_best = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        idx_next      = idx_reg;
        size_next     = size_reg;
        cap_next      = cap_reg;
        nowm_next     = nowm_reg;
        nowr_next     = nowr_reg;
        gseq_next     = gseq_reg;
        lr_seq_next   = lr_seq_reg;
        scan_cnt_next = scan_cnt_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        best_seq_next = best_seq_reg;
        best_idx_next = best_idx_reg;
        best_ent_next = best_ent_reg;
        found_next    = found_reg;
        hit_next      = hit_reg;
        res_next      = res_reg;
        tbl_req       = '0;
        new_ent       = tbl_rd_data;

        // scan compare stage, fed by the read issued in the cycle before
        if (cmp_vld_reg)
        begin
            if (take_best)
            begin
                best_seq_next = tbl_rd_data.seq;
                best_idx_next = cmp_idx_reg;
                best_ent_next = tbl_rd_data;
                found_next    = 1'b1;
            end
            if ((mode_reg == MODE_UPDATED) && (tbl_rd_data.seq > lr_seq_reg))
            begin
                hit_next = 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    mode_next     = mode;
                    idx_next      = slot_index;
                    size_next     = payload_size;
                    cap_next      = capture_time;
                    nowm_next     = now_monotonic;
                    nowr_next     = now_realtime;
                    scan_cnt_next = '0;
                    best_seq_next = (mode == MODE_OLDEST) ? '1 : '0;
                    best_idx_next = '0;
                    best_ent_next = '0;
                    found_next    = 1'b0;
                    hit_next      = 1'b0;
                    res_next            = '0;
                    res_next.found_slot = slot_index;
                    case (mode)
                        MODE_ALLOCATE, MODE_COMMIT, MODE_RELEASE, MODE_READ_SLOT:
                        begin
                            if (in_range_new)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_next.status = ST_RANGE;
                                state_next      = S_DONE;
                            end
                        end
                        MODE_NEWEST, MODE_OLDEST, MODE_UPDATED:
                        begin
                            if (n_act == '0)
                            begin
                                if (mode == MODE_NEWEST)
                                begin
                                    res_next.status     = ST_NODATA;
                                    res_next.found_slot = '0;
                                end
                                else if (mode == MODE_OLDEST)
                                begin
                                    res_next.status     = ST_RANGE;
                                    res_next.found_slot = '0;
                                end
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = SLOT_W'(idx_reg);
                state_next      = S_MODIFY;
            end

            S_MODIFY:
            begin
                tbl_req.wr_addr = SLOT_W'(idx_reg);
                case (mode_reg)
                    MODE_ALLOCATE:
                    begin
                        if (tbl_rd_data.owned)
                        begin
                            res_next.status = ST_BUSY;
                        end
                        else
                        begin
                            new_ent       = '0;
                            new_ent.owned = 1'b1;
                            tbl_req.wr_en = 1'b1;
                        end
                    end
                    MODE_COMMIT:
                    begin
                        gseq_next         = gseq_reg + 64'd1;
                        new_ent.owned     = 1'b0;
                        new_ent.seq       = gseq_next;
                        new_ent.size      = size_reg;
                        new_ent.mono_time = (cap_reg != '0) ? cap_reg : nowm_reg;
                        new_ent.real_time = nowr_reg;
                        tbl_req.wr_en     = 1'b1;
                    end
                    MODE_RELEASE:
                    begin
                        new_ent.owned = 1'b0;
                        tbl_req.wr_en = 1'b1;
                    end
                    default:
                    begin
                        new_ent = tbl_rd_data;
                    end
                endcase
                tbl_req.wr_data    = new_ent;
                res_next.seq       = new_ent.seq;
                res_next.size      = new_ent.size;
                res_next.mono_time = new_ent.mono_time;
                res_next.real_time = new_ent.real_time;
                state_next         = S_DONE;
            end

            S_SCAN:
            begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = scan_cnt_reg;
                cmp_vld_next    = 1'b1;
                cmp_idx_next    = scan_cnt_reg;
                if ((CNT_W'(scan_cnt_reg) + CNT_W'(1)) == n_act)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + SLOT_W'(1);
                end
            end

            S_DRAIN:
            begin
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                case (mode_reg)
                    MODE_NEWEST:
                    begin
                        if (!found_reg)
                        begin
                            res_next.status     = ST_NODATA;
                            res_next.found_slot = '0;
                        end
                        else
                        begin
                            if (best_seq_reg > lr_seq_reg)
                            begin
                                lr_seq_next = best_seq_reg;
                            end
                            res_next.found_slot = IDX_W'(best_idx_reg);
                            res_next.seq        = best_ent_reg.seq;
                            res_next.size       = best_ent_reg.size;
                            res_next.mono_time  = best_ent_reg.mono_time;
                            res_next.real_time  = best_ent_reg.real_time;
                            if ((expiry_time != '0) && (age >= 64'(expiry_time)))
                            begin
                                res_next.status = ST_EXPIRED;
                            end
                        end
                    end
                    MODE_OLDEST:
                    begin
                        res_next.found_slot = IDX_W'(best_idx_reg);
                        res_next.seq        = best_ent_reg.seq;
                        res_next.size       = best_ent_reg.size;
                        res_next.mono_time  = best_ent_reg.mono_time;
                        res_next.real_time  = best_ent_reg.real_time;
                    end
                    default:
                    begin
                        res_next.has_update = hit_reg;
                    end
                endcase
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            gseq_reg    <= '0;
            lr_seq_reg  <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            gseq_reg    <= gseq_next;
            lr_seq_reg  <= lr_seq_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        idx_reg      <= idx_next;
        size_reg     <= size_next;
        cap_reg      <= cap_next;
        nowm_reg     <= nowm_next;
        nowr_reg     <= nowr_next;
        scan_cnt_reg <= scan_cnt_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_seq_reg <= best_seq_next;
        best_idx_reg <= best_idx_next;
        best_ent_reg <= best_ent_next;
        found_reg    <= found_next;
        hit_reg      <= hit_next;
        res_reg      <= res_next;
    end

endmodule

FILE: rtl/latest_value_slot_manager.sv
// Top level of the latest-value slot manager: configuration, sequencer, table, result register.
// Allocate, commit, release and read_slot go through the read, modify and done states after acceptance;
// an index out of range, mode 7 or a scan with no active slots goes straight to done.
// Newest, oldest and updated scan the table at one slot read per cycle, then drain and finish.
// Requests: one at a time, taken the cycle after its result enters the output register.
// Reset: slots_in_use 16, expiry_time 2000000, counters zero; slots read as zero via valid bits,
// no clearing pass, requests taken at once.
`timescale 1ns / 1ps

module latest_value_slot_manager
    import lvsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [MODE_W-1:0]     mode,
    input  logic [IDX_W-1:0]      slot_index,
    input  logic [31:0]           payload_size,
    input  logic [63:0]           capture_time,
    input  logic [63:0]           now_monotonic,
    input  logic [63:0]           now_realtime,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [IDX_W-1:0]      found_slot,
    output logic [63:0]           slot_sequence,
    output logic [31:0]           slot_payload_size,
    output logic [63:0]           slot_capture_monotonic,
    output logic [63:0]           slot_capture_realtime,
    output logic                  has_update
);

    logic [SIU_W-1:0]      siu_reg, siu_next;
    logic [CFG_DATA_W-1:0] expiry_reg, expiry_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_res_reg, out_res_next;

    tbl_req_t tbl_req;
    entry_t   tbl_rd_data;
    logic     res_valid;
    logic     res_take;
    result_t  res;

    // Configuration: take writes straight into the registers; the host must only
    // write while no request is in flight, which the block itself does not enforce.
    always_comb
    begin
        siu_next    = siu_reg;
        expiry_next = expiry_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLOTS_IN_USE: siu_next    = cfg_data[SIU_W-1:0];
                CFG_EXPIRY_TIME:  expiry_next = cfg_data;
                default:          siu_next    = siu_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siu_reg    <= SIU_RESET;
            expiry_reg <= EXPIRY_RESET;
        end
        else
        begin
            siu_reg    <= siu_next;
            expiry_reg <= expiry_next;
        end
    end

    // Slot table: one read or one write per cycle, read data registered.
    lvsm_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

    // Sequencer: owns the global sequence and the last-read mark, walks the
    // table for scans and does the read-modify-write for single-slot requests.
    lvsm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .slot_index    (slot_index),
        .payload_size  (payload_size),
        .capture_time  (capture_time),
        .now_monotonic (now_monotonic),
        .now_realtime  (now_realtime),
        .slots_in_use  (siu_reg),
        .expiry_time   (expiry_reg),
        .tbl_req       (tbl_req),
        .tbl_rd_data   (tbl_rd_data),
        .res_valid     (res_valid),
        .res_take      (res_take),
        .res           (res)
    );

    // Output register: hold the result while the consumer stalls, and let the
    // sequencer move on to the next request once its result is parked here.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_res_next = out_res_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid              = out_valid_reg;
    assign status                 = out_res_reg.status;
    assign found_slot             = out_res_reg.found_slot;
    assign slot_sequence          = out_res_reg.seq;
    assign slot_payload_size      = out_res_reg.size;
    assign slot_capture_monotonic = out_res_reg.mono_time;
    assign slot_capture_realtime  = out_res_reg.real_time;
    assign has_update             = out_res_reg.has_update;

`ifndef SYNTH
    // an accepted request always occupies the sequencer for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted but sequencer not busy");

    // the updated query reports no slot contents
    a_update_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_update) |-> (slot_sequence == 64'd0 && status == ST_OK))
        else $error("update flag raised with slot contents");

    // only a published slot can be reported as expired
    a_expired_has_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EXPIRED) |-> (slot_sequence != 64'd0))
        else $error("expired status on an empty slot");
`endif

endmodule
